// File: src/secant_offset_zero_search_macros.svh
// Assertion macros for the secant offset zero search block.
`ifndef SECANT_OFFSET_ZERO_SEARCH_MACROS_SVH
`define SECANT_OFFSET_ZERO_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define SOZS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SOZS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SOZS_ASSERT(lbl, prop, msg)
`define SOZS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/sozs_pkg.sv
// Shared types and constants of the secant offset zero search block.
`timescale 1ns / 1ps
package sozs_pkg;

	typedef enum logic [1:0] {
		MODE_MEAS  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_IDLE   = 2'd0,
		STAT_SEARCH = 2'd1,
		STAT_FOUND  = 2'd2,
		STAT_ERROR  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_GAIN,
		OP_MUL1_LOAD,
		OP_MUL_STEP,
		OP_MUL2_LOAD,
		OP_FINISH,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
		logic   second;
	} cmd_t;

	typedef struct packed {
		logic ds_big;
		logic dp_zero;
		logic div_ovf;
		logic gain_over;
		logic found_hit;
	} stat_t;

	typedef struct packed {
		logic [31:0] target_point;
		logic [30:0] error_tolerance;
		logic [30:0] min_step;
		logic [30:0] gain_limit;
		logic [31:0] gain_initial;
		logic [16:0] damping_initial;
	} cfg_t;

	localparam logic [2:0] REG_TARGET   = 3'd0;
	localparam logic [2:0] REG_ERR_TOL  = 3'd1;
	localparam logic [2:0] REG_MIN_STEP = 3'd2;
	localparam logic [2:0] REG_GAIN_LIM = 3'd3;
	localparam logic [2:0] REG_GAIN_INI = 3'd4;
	localparam logic [2:0] REG_DAMP_INI = 3'd5;

	// quotient bits kept by the gain divider (gain_limit is 31 bits)
	localparam int DIV_BITS = 31;

endpackage

// File: src/sozs_in_if.sv
// Input word channel of the secant offset zero search block.
`timescale 1ns / 1ps
interface sozs_in_if #(parameter int VALUE_WIDTH = 32) ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             mode;
	logic [VALUE_WIDTH-1:0] measured_value;
	logic [VALUE_WIDTH-1:0] current_setpoint;

	modport source (output valid, mode, measured_value, current_setpoint, input ready);
	modport sink (input valid, mode, measured_value, current_setpoint, output ready);
endinterface

// File: src/sozs_out_if.sv
// Result word channel of the secant offset zero search block.
`timescale 1ns / 1ps
interface sozs_out_if #(parameter int VALUE_WIDTH = 32) ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] new_setpoint;
	logic                   setpoint_valid;
	logic [1:0]             search_status;

	modport source (output valid, new_setpoint, setpoint_valid, search_status, input ready);
	modport sink (input valid, new_setpoint, setpoint_valid, search_status, output ready);
endinterface

// File: src/sozs_datapath.sv
// Datapath: error, gain divider, shift-add multiplier and search registers.
`timescale 1ns / 1ps
module sozs_datapath #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sozs_pkg::cfg_t          cfg,
	input  sozs_pkg::cmd_t          cmd,
	input  logic [VALUE_WIDTH-1:0]  meas_in,
	input  logic [VALUE_WIDTH-1:0]  cur_in,
	output sozs_pkg::stat_t         st,
	output logic [VALUE_WIDTH-1:0]  new_setpoint
);
	localparam int W  = VALUE_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int TW = W + 33;
	localparam int DW = W + 32;
	localparam int OW = (W > 17) ? W : 17;
	localparam int MI = (OW + 3) / 4;
	localparam int PB = 4 * MI;
	localparam int AW = OW + PB;
	localparam int QB = sozs_pkg::DIV_BITS;

	localparam logic signed [TW-1:0] VMAX_T = (TW'(1) <<< (W - 1)) - TW'(1);
	localparam logic signed [TW-1:0] VMIN_T = -VMAX_T - TW'(1);
	localparam logic [DW-1:0] THR    = DW'(1) << (F - 2);
	localparam logic [DW-1:0] CAPD_P = (DW'(1) << (W - 1)) - DW'(1);
	localparam logic [DW-1:0] CAPD_N = DW'(1) << (W - 1);
	localparam logic [AW-1:0] CAPA_P = (AW'(1) << (W - 1)) - AW'(1);
	localparam logic [AW-1:0] CAPA_N = AW'(1) << (W - 1);

	function automatic logic [W-1:0] sat_w(input logic signed [TW-1:0] v);
		logic [W-1:0] r;
		if (v > VMAX_T)
			r = VMAX_T[W-1:0];
		else if (v < VMIN_T)
			r = VMIN_T[W-1:0];
		else
			r = v[W-1:0];
		return r;
	endfunction

	function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
		return v[W-1] ? -v : v;
	endfunction

	logic [W-1:0]  meas_q, cur_q, err_q, nxt_q, out_sp_q;
	logic [W-1:0]  gain_q, lrd_q, ldr_q, lss_q;
	logic [16:0]   damp_q;
	logic          len_q;
	logic [DW-1:0] rem_q, dv_q;
	logic [QB-1:0] quo_q;
	logic [OW-1:0] ma_q;
	logic [PB-1:0] mb_q;
	logic [AW-1:0] acc_q;
	logic          mneg_q;

	logic signed [TW-1:0] dsx, dpx, dsm, dpm;
	logic [W:0]    uds, udp;
	logic [W-1:0]  err_in, lo, lo_h, err_mag, gmw;
	logic [DW-1:0] gm, capg;
	logic          gneg, div_ge, halve;
	logic [AW-1:0] sh, capm;
	logic [OW+3:0] pp;
	logic signed [TW-1:0] sp;

	always_comb begin
		err_in = sat_w(TW'($signed(cfg.target_point)) - TW'($signed(meas_in)));
		dsx = TW'($signed(cur_q)) - TW'($signed(ldr_q));
		dpx = TW'($signed(meas_q)) - TW'($signed(lrd_q));
		dsm = dsx[TW-1] ? -dsx : dsx;
		dpm = dpx[TW-1] ? -dpx : dpx;
		uds = dsm[W:0];
		udp = dpm[W:0];
		gneg = dsx[TW-1] != dpx[TW-1];
		capg = gneg ? CAPD_N : CAPD_P;
		gm = (DW'(quo_q) > capg) ? capg : DW'(quo_q);
		gmw = gm[W-1:0];
		div_ge = rem_q >= dv_q;
		pp = {4'b0000, ma_q} * mb_q[PB-1 -: 4];
		sh = acc_q >> F;
		capm = mneg_q ? CAPA_N : CAPA_P;
		lo = (sh > capm) ? capm[W-1:0] : sh[W-1:0];
		lo_h = lo >> 1;
		err_mag = mag_w(err_q);
		halve = cmd.second && ((lo > lss_q) || (err_q[W-1] != len_q))
			&& (DW'(lo) > DW'(cfg.min_step));
		sp = TW'($signed(cur_q)) + (mneg_q ? -TW'(halve ? lo_h : lo) : TW'(halve ? lo_h : lo));
		st.ds_big    = DW'(uds) > THR;
		st.dp_zero   = (udp == '0);
		st.div_ovf   = rem_q >= (dv_q << 1);
		st.gain_over = quo_q > cfg.gain_limit;
		st.found_hit = (DW'(err_mag) <= DW'(cfg.error_tolerance))
			&& (DW'(lo) <= DW'(cfg.min_step));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			damp_q <= '0;
			lrd_q  <= '0;
			ldr_q  <= '0;
			lss_q  <= '0;
			len_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				meas_q <= meas_in;
				cur_q  <= cur_in;
				err_q  <= err_in;
				nxt_q  <= cur_in;
			end
			case (cmd.op)
				sozs_pkg::OP_START: begin
					gain_q <= sat_w(TW'($signed(cfg.gain_initial)));
					damp_q <= cfg.damping_initial;
					lrd_q  <= '0;
					ldr_q  <= '0;
					lss_q  <= '0;
					len_q  <= 1'b0;
				end
				sozs_pkg::OP_DIV_LOAD: begin
					rem_q <= DW'(uds) << F;
					dv_q  <= DW'(udp) << (QB - 1);
					quo_q <= '0;
				end
				sozs_pkg::OP_DIV_STEP: begin
					if (div_ge)
						rem_q <= rem_q - dv_q;
					quo_q <= {quo_q[QB-2:0], div_ge};
					dv_q  <= dv_q >> 1;
				end
				sozs_pkg::OP_GAIN: begin
					gain_q <= gneg ? -gmw : gmw;
				end
				sozs_pkg::OP_MUL1_LOAD: begin
					// first sample only records the error sign
					if (!cmd.second)
						len_q <= err_q[W-1];
					ma_q   <= OW'(err_mag);
					mb_q   <= PB'(mag_w(gain_q));
					acc_q  <= '0;
					mneg_q <= err_q[W-1] != gain_q[W-1];
				end
				sozs_pkg::OP_MUL_STEP: begin
					acc_q <= (acc_q << 4) + AW'(pp);
					mb_q  <= mb_q << 4;
				end
				sozs_pkg::OP_MUL2_LOAD: begin
					ma_q   <= OW'(lo);
					mb_q   <= PB'(damp_q);
					acc_q  <= '0;
					mneg_q <= mneg_q && (lo != '0);
				end
				sozs_pkg::OP_FINISH: begin
					if (halve) begin
						damp_q <= damp_q >> 1;
						lss_q  <= lo;
						len_q  <= err_q[W-1];
					end else if (!cmd.second) begin
						lss_q <= lo;
					end
					nxt_q <= sat_w(sp);
					lrd_q <= meas_q;
					ldr_q <= cur_q;
				end
				sozs_pkg::OP_OUT_LOAD: begin
					out_sp_q <= nxt_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign new_setpoint = out_sp_q;

endmodule

// File: src/sozs_ctrl.sv
// Controller: search state, sequencing of divider and multiplier, result word.
`timescale 1ns / 1ps
`include "secant_offset_zero_search_macros.svh"
module sozs_ctrl #(
	parameter int MUL_STEPS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_mode,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  setpoint_valid,
	output logic [1:0]            search_status,
	output sozs_pkg::cmd_t        cmd,
	input  sozs_pkg::stat_t       st
);
	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_DIVOV, S_DIV, S_GAIN, S_M1LD,
		S_MUL1, S_M2LD, S_MUL2, S_FIN, S_OUT
	} state_t;

	localparam logic [1:0] SC_FULL  = 2'd2;
	localparam logic [4:0] DIV_LAST = 5'(sozs_pkg::DIV_BITS - 2);
	localparam logic [4:0] MUL_LAST = 5'(MUL_STEPS - 1);

	state_t              state_q;
	sozs_pkg::status_t   srch_q, out_status_q;
	logic [1:0]          sc_q;
	logic [4:0]          cnt_q;
	logic                res_valid_q, out_valid_q, out_spv_q;
	sozs_pkg::mode_t     mode;
	logic                out_free;

	assign mode     = sozs_pkg::mode_t'(in_mode);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.capture = 1'b0;
		cmd.op      = sozs_pkg::OP_NONE;
		cmd.second  = (sc_q == SC_FULL);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (mode == sozs_pkg::MODE_START)
						cmd.op = sozs_pkg::OP_START;
				end
			end
			S_CHK: begin
				if (cmd.second && st.ds_big) begin
					if (!st.dp_zero)
						cmd.op = sozs_pkg::OP_DIV_LOAD;
				end else begin
					cmd.op = sozs_pkg::OP_MUL1_LOAD;
				end
			end
			S_DIVOV: if (!st.div_ovf) cmd.op = sozs_pkg::OP_DIV_STEP;
			S_DIV:   cmd.op = sozs_pkg::OP_DIV_STEP;
			S_GAIN:  if (!st.gain_over) cmd.op = sozs_pkg::OP_GAIN;
			S_M1LD:  cmd.op = sozs_pkg::OP_MUL1_LOAD;
			S_MUL1:  cmd.op = sozs_pkg::OP_MUL_STEP;
			S_M2LD:  cmd.op = sozs_pkg::OP_MUL2_LOAD;
			S_MUL2:  cmd.op = sozs_pkg::OP_MUL_STEP;
			S_FIN:   if (!(cmd.second && st.found_hit)) cmd.op = sozs_pkg::OP_FINISH;
			S_OUT:   if (out_free) cmd.op = sozs_pkg::OP_OUT_LOAD;
			default: cmd.op = sozs_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			srch_q       <= sozs_pkg::STAT_IDLE;
			out_status_q <= sozs_pkg::STAT_IDLE;
			sc_q         <= '0;
			cnt_q        <= '0;
			res_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_spv_q    <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_valid_q <= 1'b0;
						state_q     <= S_OUT;
						case (mode)
							sozs_pkg::MODE_START: begin
								srch_q <= sozs_pkg::STAT_SEARCH;
								sc_q   <= '0;
							end
							sozs_pkg::MODE_STOP: begin
								srch_q <= sozs_pkg::STAT_IDLE;
								sc_q   <= '0;
							end
							sozs_pkg::MODE_MEAS: begin
								if (srch_q == sozs_pkg::STAT_SEARCH) begin
									sc_q    <= (sc_q == SC_FULL) ? SC_FULL : sc_q + 2'd1;
									state_q <= S_CHK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CHK: begin
					if (cmd.second && st.ds_big) begin
						if (st.dp_zero) begin
							srch_q  <= sozs_pkg::STAT_ERROR;
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIVOV;
						end
					end else begin
						cnt_q   <= MUL_LAST;
						state_q <= S_MUL1;
					end
				end
				S_DIVOV: begin
					if (st.div_ovf) begin
						srch_q  <= sozs_pkg::STAT_ERROR;
						state_q <= S_OUT;
					end else begin
						cnt_q   <= DIV_LAST;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0)
						state_q <= S_GAIN;
				end
				S_GAIN: begin
					if (st.gain_over) begin
						srch_q  <= sozs_pkg::STAT_ERROR;
						state_q <= S_OUT;
					end else begin
						state_q <= S_M1LD;
					end
				end
				S_M1LD: begin
					cnt_q   <= MUL_LAST;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0)
						state_q <= S_M2LD;
				end
				S_M2LD: begin
					cnt_q   <= MUL_LAST;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (cmd.second && st.found_hit)
						srch_q <= sozs_pkg::STAT_FOUND;
					else
						res_valid_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the result register is free
					if (out_free) begin
						out_spv_q    <= res_valid_q;
						out_status_q <= srch_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign setpoint_valid = out_spv_q;
	assign search_status  = out_status_q;

	`SOZS_ASSERT(a_spv_searching, (out_valid_q && out_spv_q) |-> (out_status_q == sozs_pkg::STAT_SEARCH), "setpoint word without searching status")
	`SOZS_ASSERT(a_div_count, (state_q == S_DIV) |-> (cnt_q <= DIV_LAST), "divider count out of range")
	`SOZS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_q != S_IDLE, "accepted word left controller idle")
	`SOZS_ASSERT_NEXT(a_out_load, state_q == S_OUT && out_free, out_valid_q, "result word not loaded")

endmodule

// File: src/secant_offset_zero_search.sv
// Top level of the secant offset zero search block: register port and wiring.
`timescale 1ns / 1ps
// One result word per input word. Start, stop and ignored words go straight to the
// output state. A measurement during a search runs the four-bits-a-cycle shift-add
// multiplier in two passes and, before them when the gain is updated, the
// one-quotient-bit-a-cycle gain divider. The next word is taken once the result
// sits in the output register; a result waits there while the sink stalls.
// Registers lie at byte address 4*i over a 32-bit register port.
module secant_offset_zero_search #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sozs_in_if.sink     in_ch,
	sozs_out_if.source  out_ch
);
	localparam int OW        = (VALUE_WIDTH > 17) ? VALUE_WIDTH : 17;
	localparam int MUL_STEPS = (OW + 3) / 4;

	sozs_pkg::cfg_t  cfg_q;
	sozs_pkg::cmd_t  cmd;
	sozs_pkg::stat_t st;
	logic [2:0]      reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_point    <= 32'd0;
			cfg_q.error_tolerance <= 31'd655;
			cfg_q.min_step        <= 31'd655;
			cfg_q.gain_limit      <= 31'd6553600;
			cfg_q.gain_initial    <= 32'd65536;
			cfg_q.damping_initial <= 17'd65536;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				sozs_pkg::REG_TARGET:   cfg_q.target_point    <= pwdata;
				sozs_pkg::REG_ERR_TOL:  cfg_q.error_tolerance <= pwdata[30:0];
				sozs_pkg::REG_MIN_STEP: cfg_q.min_step        <= pwdata[30:0];
				sozs_pkg::REG_GAIN_LIM: cfg_q.gain_limit      <= pwdata[30:0];
				sozs_pkg::REG_GAIN_INI: cfg_q.gain_initial    <= pwdata;
				sozs_pkg::REG_DAMP_INI: cfg_q.damping_initial <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sozs_pkg::REG_TARGET:   prdata = cfg_q.target_point;
			sozs_pkg::REG_ERR_TOL:  prdata = {1'b0, cfg_q.error_tolerance};
			sozs_pkg::REG_MIN_STEP: prdata = {1'b0, cfg_q.min_step};
			sozs_pkg::REG_GAIN_LIM: prdata = {1'b0, cfg_q.gain_limit};
			sozs_pkg::REG_GAIN_INI: prdata = cfg_q.gain_initial;
			sozs_pkg::REG_DAMP_INI: prdata = {15'd0, cfg_q.damping_initial};
			default:                prdata = 32'd0;
		endcase
	end

	sozs_ctrl #(
		.MUL_STEPS(MUL_STEPS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_mode        (in_ch.mode),
		.in_ready       (in_ch.ready),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.setpoint_valid (out_ch.setpoint_valid),
		.search_status  (out_ch.search_status),
		.cmd            (cmd),
		.st             (st)
	);

	sozs_datapath #(
		.VALUE_WIDTH   (VALUE_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.meas_in      (in_ch.measured_value),
		.cur_in       (in_ch.current_setpoint),
		.st           (st),
		.new_setpoint (out_ch.new_setpoint)
	);

endmodule
